FILE: rtl/pbvo_pkg.sv
// Package for the PolyBLEP voice oscillator: widths, waveform codes,
// CORDIC arctangent table. No dependencies.
`default_nettype none
package pbvo_pkg;

    localparam int SampleBits = 16;
    localparam int PhaseBits  = 32;
    localparam int PhaseUp    = 32 - PhaseBits;
    localparam int OutShift   = 46 - SampleBits;

    localparam logic [16:0] OneQ15   = 17'd32768;
    localparam logic [15:0] GainSnap = 16'd4;
    localparam logic signed [32:0] CordicX0 = 33'sd652032874;
    localparam int CordicSteps = 16;
    localparam int DivSteps    = 15;

    typedef logic signed [19:0] t_wave;

    typedef enum logic [2:0] {
        WAVE_SINE     = 3'd0,
        WAVE_SQUARE   = 3'd1,
        WAVE_SAW      = 3'd2,
        WAVE_TRIANGLE = 3'd3,
        WAVE_NOISE    = 3'd4
    } t_wave_sel;

    typedef enum logic [2:0] {
        REG_WAVEFORM   = 3'd0,
        REG_PHASE_STEP = 3'd1,
        REG_VOLUME     = 3'd2,
        REG_PAN        = 3'd3,
        REG_RAMP_COEF  = 3'd4,
        REG_NOISE_SEED = 3'd5
    } t_reg_idx;

    function automatic logic signed [32:0] atan_turn(input logic [3:0] idx);
        logic signed [32:0] v;
        case (idx)
            4'd0:    v = 33'sd536870912;
            4'd1:    v = 33'sd316933406;
            4'd2:    v = 33'sd167458907;
            4'd3:    v = 33'sd85004756;
            4'd4:    v = 33'sd42667331;
            4'd5:    v = 33'sd21354465;
            4'd6:    v = 33'sd10679838;
            4'd7:    v = 33'sd5340245;
            4'd8:    v = 33'sd2670163;
            4'd9:    v = 33'sd1335087;
            4'd10:   v = 33'sd667544;
            4'd11:   v = 33'sd333772;
            4'd12:   v = 33'sd166886;
            4'd13:   v = 33'sd83443;
            4'd14:   v = 33'sd41722;
            default: v = 33'sd20861;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pbvo_div.sv
// Restoring divider, one quotient bit per cycle, for the PolyBLEP fraction.
// Numerator is below denominator. Depends on pbvo_pkg.
`default_nettype none
module pbvo_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic [14:0]      o_quot,
    output logic             o_done
);
    import pbvo_pkg::*;

    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [14:0] r_quot;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_shift;
    logic        n_ge;

    always_comb begin
        n_shift = {r_rem[31:0], 1'b0};
        n_ge    = n_shift >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_cnt  <= 4'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= n_ge ? n_shift - {1'b0, r_den} : n_shift;
                r_quot <= {r_quot[13:0], n_ge};
                r_cnt  <= r_cnt + 4'd1;
                if (r_cnt == 4'(DivSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;
endmodule
`default_nettype wire

FILE: rtl/pbvo_cordic.sv
// Iterative 16-step CORDIC sine, one rotation per cycle, phase in turns.
// Depends on pbvo_pkg.
`default_nettype none
module pbvo_cordic (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_phase,
    output pbvo_pkg::t_wave  o_sine,
    output logic             o_done
);
    import pbvo_pkg::*;

    logic signed [32:0] r_x, r_y, r_a;
    logic [3:0]         r_idx;
    logic               r_busy;
    logic               r_done;
    logic signed [32:0] n_a0, n_dx, n_dy, n_round;

    always_comb begin
        if (i_phase >= 32'h4000_0000 && i_phase < 32'hC000_0000) begin
            n_a0 = 33'sh0_8000_0000 - $signed({1'b0, i_phase});
        end else if (i_phase >= 32'hC000_0000) begin
            n_a0 = $signed({1'b1, i_phase});
        end else begin
            n_a0 = $signed({1'b0, i_phase});
        end
        n_dx    = r_y >>> r_idx;
        n_dy    = r_x >>> r_idx;
        n_round = (r_y + 33'sd16384) >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= CordicX0;
                r_y    <= '0;
                r_a    <= n_a0;
                r_idx  <= 4'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_a[32]) begin
                    r_x <= r_x - n_dx;
                    r_y <= r_y + n_dy;
                    r_a <= r_a - atan_turn(r_idx);
                end else begin
                    r_x <= r_x + n_dx;
                    r_y <= r_y - n_dy;
                    r_a <= r_a + atan_turn(r_idx);
                end
                r_idx <= r_idx + 4'd1;
                if (r_idx == 4'(CordicSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sine = t_wave'(n_round);
    assign o_done = r_done;
endmodule
`default_nettype wire

FILE: rtl/polyblep_voice_oscillator.sv
// Top level of the PolyBLEP voice oscillator: config registers, sequencer, multiplies.
// Depends on pbvo_pkg, pbvo_div, pbvo_cordic.
//
// channel  direction  handshake            payload
// input    in         i_valid / i_ready    i_voice_on, i_paused, i_block_last
// output   out        o_valid / o_ready    o_left_sample, o_right_sample
// config   in         i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// Paused or silent items go straight to S_OUT; triangle and noise pass S_GAIN, S_WAVE
// and the multiplies; sine adds 16 CORDIC rotations. Saw adds S_BLEP and S_ACC; square
// passes them once per edge; each edge in reach of the step adds a run of the divider.
// Synchronous active-low reset; i_ready is low while an item is in work.
// A finished item waits in the output register; the next item is taken meanwhile.
// With the output register full and o_ready low, a finished item holds in S_OUT.
`default_nettype none
module polyblep_voice_oscillator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             i_ready,
    input  wire logic        i_voice_on,
    input  wire logic        i_paused,
    input  wire logic        i_block_last,
    output logic             o_valid,
    input  wire logic        o_ready,
    output logic signed [pbvo_pkg::SampleBits-1:0] o_left_sample,
    output logic signed [pbvo_pkg::SampleBits-1:0] o_right_sample,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import pbvo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_GAIN, S_WAVE, S_CORDIC, S_BLEP, S_DIV, S_ACC,
        S_MUL_S, S_MUL_L, S_MUL_R, S_OUT
    } t_state;

    t_state r_state;
    logic [2:0]  r_wave_sel;
    logic [31:0] r_phase_step;
    logic [15:0] r_volume;
    logic signed [15:0] r_pan;
    logic [15:0] r_ramp_coef;
    logic [31:0] r_noise_seed;
    logic [PhaseBits-1:0] r_phase_acc;
    logic [15:0] r_gain;
    logic [31:0] r_noise;
    logic r_on, r_last, r_k, r_neg;
    t_wave r_w;
    logic [15:0] r_sq;
    logic signed [37:0] r_s;
    logic signed [SampleBits-1:0] r_left, r_right;
    logic r_o_valid;
    logic signed [SampleBits-1:0] r_o_left, r_o_right;

    logic [31:0] n_p, n_dt, n_t, n_tri_d;
    logic [32:0] n_r;
    logic signed [17:0] n_target, n_diff;
    logic [15:0] n_absd, n_mag;
    logic [31:0] n_prod;
    logic [31:0] n_noise;
    logic signed [17:0] n_gl, n_gr, n_pg;
    logic signed [55:0] n_x;
    logic signed [SampleBits-1:0] n_sat;
    logic [15:0] n_dq;
    logic [31:0] n_dsq;
    logic signed [16:0] n_blep;
    logic n_div_start, n_cordic_start, n_case_lo, n_case_hi, n_sub;
    logic [14:0] w_quot;
    logic w_div_done, w_cordic_done;
    t_wave w_sine;

    pbvo_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_div_start),
        .i_num(n_case_lo ? n_t : n_r[31:0]), .i_den(n_dt),
        .o_quot(w_quot), .o_done(w_div_done)
    );

    pbvo_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_cordic_start),
        .i_phase(n_p), .o_sine(w_sine), .o_done(w_cordic_done)
    );

    function automatic logic signed [SampleBits-1:0] out_sample(input logic signed [55:0] x);
        logic signed [55:0] v;
        v = (x + (56'sd1 <<< (OutShift - 1))) >>> OutShift;
        if (v > 56'sd0 + ((56'sd1 <<< (SampleBits - 1)) - 56'sd1)) begin
            return {1'b0, {(SampleBits - 1){1'b1}}};
        end else if (v < -(56'sd1 <<< (SampleBits - 1))) begin
            return {1'b1, {(SampleBits - 1){1'b0}}};
        end
        return v[SampleBits-1:0];
    endfunction

    always_comb begin
        n_p  = 32'(r_phase_acc) << PhaseUp;
        n_dt = 32'(r_phase_step[PhaseBits-1:0]) << PhaseUp;
        n_t  = r_k ? n_p + 32'h8000_0000 : n_p;
        n_r  = 33'h1_0000_0000 - {1'b0, n_t};
        n_case_lo = n_t < n_dt;
        n_case_hi = !n_case_lo && (n_r < {1'b0, n_dt});
        n_tri_d = n_p >= 32'h8000_0000 ? n_p - 32'h8000_0000 : 32'h8000_0000 - n_p;

        n_target = !r_on ? 18'sd0 :
                   (r_volume > OneQ15[15:0] || r_volume == 16'h8000) ?
                   $signed({1'b0, OneQ15}) : $signed({2'b00, r_volume});
        n_diff = n_target - $signed({2'b00, r_gain});
        n_absd = n_diff[17] ? 16'(-n_diff) : n_diff[15:0];
        n_prod = n_absd * r_ramp_coef;
        n_mag  = (n_prod[31:16] == 16'd0 && n_diff != 18'sd0) ? 16'd1 : n_prod[31:16];

        n_noise = r_noise ^ (r_noise << 13);
        n_noise = n_noise ^ (n_noise >> 17);
        n_noise = n_noise ^ (n_noise << 5);

        n_gl = r_pan > 16'sd0 ? $signed({1'b0, OneQ15}) - 18'(r_pan) : $signed({1'b0, OneQ15});
        n_gr = r_pan < 16'sd0 ? $signed({1'b0, OneQ15}) + 18'(r_pan) : $signed({1'b0, OneQ15});
        n_pg = (r_state == S_MUL_L) ? n_gl : n_gr;
        n_x  = r_s * n_pg;
        n_sat = out_sample(n_x);

        n_dq  = 16'(OneQ15 - {2'b00, w_quot});
        n_dsq = n_dq * n_dq;
        n_blep = r_neg ? -$signed({1'b0, r_sq}) : $signed({1'b0, r_sq});
        n_sub  = (r_wave_sel == WAVE_SAW) || r_k;

        n_div_start    = (r_state == S_BLEP) && (n_case_lo || n_case_hi);
        n_cordic_start = (r_state == S_WAVE) && !(r_wave_sel inside
                         {WAVE_SQUARE, WAVE_SAW, WAVE_TRIANGLE, WAVE_NOISE});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_o_valid    <= 1'b0;
            r_wave_sel   <= 3'd0;
            r_phase_step <= '0;
            r_volume     <= '0;
            r_pan        <= '0;
            r_ramp_coef  <= 16'd297;
            r_noise_seed <= 32'd2463534242;
            r_noise      <= 32'd2463534242;
            r_phase_acc  <= '0;
            r_gain       <= '0;
        end else begin
            if (r_o_valid && o_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_WAVEFORM:   r_wave_sel   <= i_cfg_data[2:0];
                    REG_PHASE_STEP: r_phase_step <= i_cfg_data;
                    REG_VOLUME:     r_volume     <= i_cfg_data[15:0];
                    REG_PAN:        r_pan        <= i_cfg_data[15:0];
                    REG_RAMP_COEF:  r_ramp_coef  <= i_cfg_data[15:0];
                    REG_NOISE_SEED: begin
                        r_noise_seed <= i_cfg_data;
                        r_noise      <= i_cfg_data;
                    end
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_on   <= i_voice_on;
                        r_last <= i_block_last;
                        if (i_paused || (!i_voice_on && r_gain == 16'd0)) begin
                            r_left  <= '0;
                            r_right <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_GAIN;
                        end
                    end
                end
                S_GAIN: begin
                    r_gain  <= n_diff[17] ? r_gain - n_mag : r_gain + n_mag;
                    r_k     <= 1'b0;
                    r_state <= S_WAVE;
                end
                S_WAVE: begin
                    unique case (r_wave_sel)
                        WAVE_SQUARE: begin
                            r_w     <= n_p < 32'h8000_0000 ? 20'sd32768 : -20'sd32768;
                            r_state <= S_BLEP;
                        end
                        WAVE_SAW: begin
                            r_w     <= $signed({4'd0, n_p[31:16]}) - 20'sd32768;
                            r_state <= S_BLEP;
                        end
                        WAVE_TRIANGLE: begin
                            r_w     <= 20'sd32768 - $signed({3'd0, n_tri_d[31:15]});
                            r_state <= S_MUL_S;
                        end
                        WAVE_NOISE: begin
                            r_noise <= n_noise;
                            r_w     <= $signed({4'd0, n_noise[31:16]}) - 20'sd32768;
                            r_state <= S_MUL_S;
                        end
                        default: r_state <= S_CORDIC;
                    endcase
                end
                S_CORDIC: begin
                    if (w_cordic_done) begin
                        r_w     <= w_sine;
                        r_state <= S_MUL_S;
                    end
                end
                S_BLEP: begin
                    r_neg <= n_case_lo;
                    if (n_case_lo || n_case_hi) begin
                        r_state <= S_DIV;
                    end else begin
                        r_sq    <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_sq    <= n_dsq[30:15];
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_w <= n_sub ? r_w - 20'(n_blep) : r_w + 20'(n_blep);
                    if (r_wave_sel == WAVE_SQUARE && !r_k) begin
                        r_k     <= 1'b1;
                        r_state <= S_BLEP;
                    end else begin
                        r_state <= S_MUL_S;
                    end
                end
                S_MUL_S: begin
                    r_s     <= r_w * $signed({1'b0, r_gain});
                    r_state <= S_MUL_L;
                end
                S_MUL_L: begin
                    r_left  <= n_sat;
                    r_state <= S_MUL_R;
                end
                S_MUL_R: begin
                    r_right     <= n_sat;
                    r_phase_acc <= r_phase_acc + r_phase_step[PhaseBits-1:0];
                    if (r_last && !r_on && r_gain < GainSnap) begin
                        r_gain <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || o_ready) begin
                        r_o_left  <= r_left;
                        r_o_right <= r_right;
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_left_sample  = r_o_left;
    assign o_right_sample = r_o_right;
endmodule
`default_nettype wire

FILE: rtl/pbvo_checker.sv
// Port-level checks for the PolyBLEP voice oscillator, bound to the top level.
// Depends on pbvo_pkg.
`default_nettype none
module pbvo_port_checks (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic i_ready,
    input wire logic o_valid,
    input wire logic o_ready,
    input wire logic signed [pbvo_pkg::SampleBits-1:0] o_left_sample,
    input wire logic signed [pbvo_pkg::SampleBits-1:0] o_right_sample
);
    import pbvo_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_left_sample) && $stable(o_right_sample))
        else $error("output item changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready |=> !i_ready)
        else $error("ready stayed high after an item was taken");

    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> i_ready)
        else $error("result shown while still busy");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && i_ready)
        else $error("bad state after reset");
endmodule

bind polyblep_voice_oscillator pbvo_port_checks u_pbvo_port_checks (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready(i_ready),
    .o_valid(o_valid), .o_ready(o_ready),
    .o_left_sample(o_left_sample), .o_right_sample(o_right_sample)
);
`default_nettype wire
